// ----- src/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared widths, codes, tables and controller/datapath interface types for
// the SBC stream frame analyzer.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int TABLE_SLOTS_DEF        = 32;
   localparam int RATE_FRACTION_BITS_DEF = 10;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int LEN_W   = 11;
   localparam int SB_W    = 4;
   localparam int BLK_W   = 5;
   localparam int SLOT_W  = 6;
   localparam int RATE_W  = 23;
   localparam int COUNT_W = 24;
   localparam int SUM_W   = 48;
   localparam int F10_W   = 9;
   localparam int DEN_W   = 11;
   localparam int PROD_W  = LEN_W + F10_W;

   localparam logic [BYTE_W-1:0]  SYNC_BYTE = 8'h9C;
   localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_FRAME           = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUM_OK          = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUM_BAD_SYNC    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUM_PART_HEADER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SUM_PART_BODY   = 3'd4;

   function automatic logic [F10_W-1:0] freq_tenths(input logic [1:0] code);
      case (code)
         2'd0:    freq_tenths = 9'd160;
         2'd1:    freq_tenths = 9'd320;
         2'd2:    freq_tenths = 9'd441;
         default: freq_tenths = 9'd480;
      endcase
   endfunction

   typedef struct packed {
      logic take_byte;
      logic len_calc;
      logic mul_calc;
      logic div_frame_start;
      logic div_sum_start;
      logic rate_store;
      logic scan_read;
      logic scan_cmp;
      logic frame_commit;
      logic sum_emit;
   } cmd_type;

   typedef struct packed {
      logic eos;
      logic header_last;
      logic div_busy;
      logic scan_end;
      logic out_free;
   } stat_type;

endpackage

// ----- src/sfa_div.sv -----
// ----------------------------------------------------------------------------
// sfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfa_div #(
   parameter int DW = 49,
   parameter int VW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quot_ff;
   logic [VW-1:0] rem_ff, rem_in, dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [VW:0]   trial;
   logic          ge;

   always_comb begin
      trial  = {rem_ff, quot_ff[DW-1]};
      ge     = (trial >= {1'b0, dsr_ff});
      rem_in = ge ? VW'(trial - {1'b0, dsr_ff}) : trial[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(DW);
         quot_ff <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[DW-2:0], ge};
         cnt_ff  <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;
endmodule

// ----- src/sfa_datapath.sv -----
// ----------------------------------------------------------------------------
// sfa_datapath
// Parse state, frame length and rate arithmetic, value tables, counters and
// the result register.
// ----------------------------------------------------------------------------
module sfa_datapath #(
   parameter int TABLE_SLOTS        = 32,
   parameter int RATE_FRACTION_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfa_pkg::cmd_type                cmd,
   output sfa_pkg::stat_type               stat,
   input  logic [sfa_pkg::BYTE_W-1:0]      req_stream_byte,
   input  logic                            req_end_of_stream,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfa_pkg::KIND_W-1:0]      rsp_result_kind,
   output logic [sfa_pkg::BYTE_W-1:0]      rsp_bitpool_value,
   output logic [sfa_pkg::LEN_W-1:0]       rsp_frame_bytes,
   output logic [sfa_pkg::SB_W-1:0]        rsp_subband_count,
   output logic [sfa_pkg::BLK_W-1:0]       rsp_block_count,
   output logic [1:0]                      rsp_freq_code,
   output logic [1:0]                      rsp_audio_mode,
   output logic                            rsp_snr_allocation,
   output logic [sfa_pkg::SLOT_W-1:0]      rsp_bitpool_slot,
   output logic [sfa_pkg::SLOT_W-1:0]      rsp_length_slot,
   output logic [sfa_pkg::RATE_W-1:0]      rsp_rate_value,
   output logic [sfa_pkg::COUNT_W-1:0]     rsp_frame_total
);
   import sfa_pkg::*;

   localparam int AW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int FW    = $clog2(TABLE_SLOTS + 1);
   localparam int SHIFT = 3 + RATE_FRACTION_BITS;
   localparam int NUM_W = PROD_W + SHIFT + 1;
   localparam int DIV_W = (NUM_W > SUM_W + 1) ? NUM_W : SUM_W + 1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_HALTED
   } phase_type;

   phase_type         phase_ff;
   logic [1:0]        hpos_ff;
   logic [BYTE_W-1:0] hb1_ff, hb2_ff;
   logic [LEN_W-1:0]  remain_ff, remain_dec;
   logic [FW-1:0]     fill_bp_ff, fill_len_ff, idx_ff;
   logic [COUNT_W-1:0] frames_ff, frames_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W:0]    sum_wide;

   logic [LEN_W-1:0]  body_ff, fbytes_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [RATE_W-1:0] rate_ff, q_sat;

   logic [BYTE_W-1:0] bp_mem [TABLE_SLOTS];
   logic [LEN_W-1:0]  len_mem [TABLE_SLOTS];
   logic [BYTE_W-1:0] bp_rd_ff;
   logic [LEN_W-1:0]  len_rd_ff;
   logic              bp_found_ff, len_found_ff;
   logic [FW-1:0]     bp_hit_ff, len_hit_ff, bp_slot, len_slot;
   logic              bp_append, len_append;

   logic [SB_W-1:0]   sb;
   logic [BLK_W-1:0]  blk;
   logic [12:0]       tpart, tval;
   logic [LEN_W-1:0]  sbterm, body;
   logic [7:0]        sbblk;

   logic              div_start, div_busy;
   logic [DIV_W-1:0]  div_dividend, div_quot;
   logic [COUNT_W-1:0] div_divisor;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] sum_kind;

   // header decode
   always_comb begin
      sb     = hb1_ff[0] ? SB_W'(8) : SB_W'(4);
      blk    = {BLK_W'(hb1_ff[5:4]) + BLK_W'(1)} << 2;
      tpart  = 13'(blk) * 13'(hb2_ff);
      sbterm = LEN_W'(sb);
      case (hb1_ff[3:2])
         2'd0: begin
            sbterm = LEN_W'(sb >> 1);
            tval   = tpart;
         end
         2'd1:    tval = tpart << 1;
         2'd2:    tval = tpart;
         default: tval = tpart + 13'(sb);
      endcase
      body  = sbterm + LEN_W'((tval + 13'd7) >> 3);
      sbblk = 8'(sb) * 8'(blk);
   end

   always_comb begin
      remain_dec = (remain_ff != '0) ? remain_ff - LEN_W'(1) : remain_ff;
      div_start  = cmd.div_frame_start | cmd.div_sum_start;
      if (cmd.div_sum_start) begin
         div_dividend = DIV_W'(sum_ff) + DIV_W'(frames_ff >> 1);
         div_divisor  = frames_ff;
      end else begin
         div_dividend = (DIV_W'(prod_ff) << SHIFT) + DIV_W'(den_ff >> 1);
         div_divisor  = COUNT_W'(den_ff);
      end
      q_sat = (div_quot > DIV_W'(RATE_MAX)) ? RATE_MAX : div_quot[RATE_W-1:0];

      bp_append  = !bp_found_ff && (fill_bp_ff < FW'(TABLE_SLOTS));
      len_append = !len_found_ff && (fill_len_ff < FW'(TABLE_SLOTS));
      bp_slot    = bp_found_ff ? bp_hit_ff : (bp_append ? fill_bp_ff : FW'(TABLE_SLOTS));
      len_slot   = len_found_ff ? len_hit_ff : (len_append ? fill_len_ff : FW'(TABLE_SLOTS));

      if (frames_ff < COUNT_MAX) begin
         frames_in = frames_ff + COUNT_W'(1);
         sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(rate_ff);
         sum_in    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end else begin
         frames_in = frames_ff;
         sum_wide  = {1'b0, sum_ff};
         sum_in    = sum_ff;
      end

      case (phase_ff)
         PH_HALTED:  sum_kind = KIND_SUM_BAD_SYNC;
         PH_PAYLOAD: sum_kind = KIND_SUM_PART_BODY;
         default:    sum_kind = (hpos_ff != 2'd0) ? KIND_SUM_PART_HEADER : KIND_SUM_OK;
      endcase
   end

   sfa_div #(.DW(DIV_W), .VW(COUNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // parse state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hpos_ff     <= 2'd0;
         remain_ff   <= '0;
         fill_bp_ff  <= '0;
         fill_len_ff <= '0;
         frames_ff   <= '0;
         sum_ff      <= '0;
      end else if (cmd.take_byte) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               remain_ff <= remain_dec;
               if (remain_dec == '0) begin
                  phase_ff <= PH_HEADER;
               end
            end
            PH_HEADER: begin
               case (hpos_ff)
                  2'd0: begin
                     if (req_stream_byte != SYNC_BYTE) begin
                        phase_ff <= PH_HALTED;
                     end else begin
                        hpos_ff <= 2'd1;
                     end
                  end
                  2'd1: begin
                     hb1_ff  <= req_stream_byte;
                     hpos_ff <= 2'd2;
                  end
                  default: begin
                     hb2_ff  <= req_stream_byte;
                     hpos_ff <= 2'd3;
                  end
               endcase
            end
            default: ;
         endcase
      end else if (cmd.frame_commit) begin
         hpos_ff   <= 2'd0;
         remain_ff <= body_ff;
         phase_ff  <= (body_ff != '0) ? PH_PAYLOAD : PH_HEADER;
         frames_ff <= frames_in;
         sum_ff    <= sum_in;
         if (bp_append) begin
            fill_bp_ff <= fill_bp_ff + FW'(1);
         end
         if (len_append) begin
            fill_len_ff <= fill_len_ff + FW'(1);
         end
      end
   end

   // frame arithmetic and table scan
   always_ff @(posedge clock) begin
      if (cmd.len_calc) begin
         body_ff   <= body;
         fbytes_ff <= body + LEN_W'(4);
         den_ff    <= DEN_W'(sbblk) * DEN_W'(10);
      end
      if (cmd.mul_calc) begin
         prod_ff <= PROD_W'(fbytes_ff) * PROD_W'(freq_tenths(hb1_ff[7:6]));
      end
      if (cmd.rate_store) begin
         rate_ff      <= q_sat;
         idx_ff       <= '0;
         bp_found_ff  <= 1'b0;
         len_found_ff <= 1'b0;
      end
      if (cmd.scan_read) begin
         bp_rd_ff  <= bp_mem[idx_ff[AW-1:0]];
         len_rd_ff <= len_mem[idx_ff[AW-1:0]];
      end
      if (cmd.scan_cmp) begin
         if (!bp_found_ff && idx_ff < fill_bp_ff && bp_rd_ff == hb2_ff) begin
            bp_found_ff <= 1'b1;
            bp_hit_ff   <= idx_ff;
         end
         if (!len_found_ff && idx_ff < fill_len_ff && len_rd_ff == fbytes_ff) begin
            len_found_ff <= 1'b1;
            len_hit_ff   <= idx_ff;
         end
         idx_ff <= idx_ff + FW'(1);
      end
      if (cmd.frame_commit && bp_append) begin
         bp_mem[fill_bp_ff[AW-1:0]] <= hb2_ff;
      end
      if (cmd.frame_commit && len_append) begin
         len_mem[fill_len_ff[AW-1:0]] <= fbytes_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.frame_commit || cmd.sum_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.frame_commit) begin
         rsp_result_kind    <= KIND_FRAME;
         rsp_bitpool_value  <= hb2_ff;
         rsp_frame_bytes    <= fbytes_ff;
         rsp_subband_count  <= sb;
         rsp_block_count    <= blk;
         rsp_freq_code      <= hb1_ff[7:6];
         rsp_audio_mode     <= hb1_ff[3:2];
         rsp_snr_allocation <= hb1_ff[1];
         rsp_bitpool_slot   <= SLOT_W'(bp_slot);
         rsp_length_slot    <= SLOT_W'(len_slot);
         rsp_rate_value     <= rate_ff;
         rsp_frame_total    <= frames_in;
      end else if (cmd.sum_emit) begin
         rsp_result_kind    <= sum_kind;
         rsp_bitpool_value  <= '0;
         rsp_frame_bytes    <= '0;
         rsp_subband_count  <= '0;
         rsp_block_count    <= '0;
         rsp_freq_code      <= '0;
         rsp_audio_mode     <= '0;
         rsp_snr_allocation <= 1'b0;
         rsp_bitpool_slot   <= '0;
         rsp_length_slot    <= '0;
         rsp_rate_value     <= (frames_ff == '0) ? '0 : q_sat;
         rsp_frame_total    <= frames_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign stat.eos         = req_end_of_stream;
   assign stat.header_last = (phase_ff == PH_HEADER) && (hpos_ff == 2'd3);
   assign stat.div_busy    = div_busy;
   assign stat.scan_end    = (idx_ff >= fill_bp_ff) && (idx_ff >= fill_len_ff);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;
endmodule

// ----- src/sfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfa_ctrl
// Sequencer: accepts items, steps the datapath through frame and summary
// work.
// ----------------------------------------------------------------------------
module sfa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sfa_pkg::stat_type  stat,
   output sfa_pkg::cmd_type   cmd
);
   import sfa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEN,
      S_MUL,
      S_DIV_START,
      S_DIV_WAIT,
      S_RATE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_FRAME_OUT,
      S_SUM_WAIT,
      S_SUM_OUT
   } state_type;

   state_type state_ff;

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (stat.eos) begin
                  cmd.div_sum_start = 1'b1;
               end else if (!stat.header_last) begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         S_LEN:       cmd.len_calc        = 1'b1;
         S_MUL:       cmd.mul_calc        = 1'b1;
         S_DIV_START: cmd.div_frame_start = 1'b1;
         S_RATE:      cmd.rate_store      = 1'b1;
         S_SCAN_RD:   cmd.scan_read       = !stat.scan_end;
         S_SCAN_CMP:  cmd.scan_cmp        = 1'b1;
         S_FRAME_OUT: cmd.frame_commit    = stat.out_free;
         S_SUM_OUT:   cmd.sum_emit        = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && stat.eos) begin
                  state_ff <= S_SUM_WAIT;
               end else if (req_valid && stat.header_last) begin
                  state_ff <= S_LEN;
               end
            end
            S_LEN:       state_ff <= S_MUL;
            S_MUL:       state_ff <= S_DIV_START;
            S_DIV_START: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (!stat.div_busy) begin
                  state_ff <= S_RATE;
               end
            end
            S_RATE:      state_ff <= S_SCAN_RD;
            S_SCAN_RD:   state_ff <= stat.scan_end ? S_FRAME_OUT : S_SCAN_CMP;
            S_SCAN_CMP:  state_ff <= S_SCAN_RD;
            S_FRAME_OUT: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_SUM_WAIT: begin
               if (!stat.div_busy) begin
                  state_ff <= S_SUM_OUT;
               end
            end
            S_SUM_OUT: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:     state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- src/sbc_stream_frame_analyzer.sv -----
// ----------------------------------------------------------------------------
// sbc_stream_frame_analyzer
// Payload and header bytes are accepted one per cycle while the sequencer is
// idle. Last header byte: frame length, then rate through the 49-step shared
// divider, then a scan that reads and compares each table entry in turn.
// End marker: mean rate through the same divider.
// Reset: synchronous; clears parse state, fill counts and counters; no
// clearing pass is needed since fill counts mark valid table entries.
// ----------------------------------------------------------------------------
module sbc_stream_frame_analyzer #(
   parameter int TABLE_SLOTS        = sfa_pkg::TABLE_SLOTS_DEF,
   parameter int RATE_FRACTION_BITS = sfa_pkg::RATE_FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfa_pkg::BYTE_W-1:0]      req_stream_byte,
   input  logic                            req_end_of_stream,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sfa_pkg::KIND_W-1:0]      rsp_result_kind,
   output logic [sfa_pkg::BYTE_W-1:0]      rsp_bitpool_value,
   output logic [sfa_pkg::LEN_W-1:0]       rsp_frame_bytes,
   output logic [sfa_pkg::SB_W-1:0]        rsp_subband_count,
   output logic [sfa_pkg::BLK_W-1:0]       rsp_block_count,
   output logic [1:0]                      rsp_freq_code,
   output logic [1:0]                      rsp_audio_mode,
   output logic                            rsp_snr_allocation,
   output logic [sfa_pkg::SLOT_W-1:0]      rsp_bitpool_slot,
   output logic [sfa_pkg::SLOT_W-1:0]      rsp_length_slot,
   output logic [sfa_pkg::RATE_W-1:0]      rsp_rate_value,
   output logic [sfa_pkg::COUNT_W-1:0]     rsp_frame_total
);
   import sfa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfa_datapath #(
      .TABLE_SLOTS        (TABLE_SLOTS),
      .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_stream_byte    (req_stream_byte),
      .req_end_of_stream  (req_end_of_stream),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_bitpool_value  (rsp_bitpool_value),
      .rsp_frame_bytes    (rsp_frame_bytes),
      .rsp_subband_count  (rsp_subband_count),
      .rsp_block_count    (rsp_block_count),
      .rsp_freq_code      (rsp_freq_code),
      .rsp_audio_mode     (rsp_audio_mode),
      .rsp_snr_allocation (rsp_snr_allocation),
      .rsp_bitpool_slot   (rsp_bitpool_slot),
      .rsp_length_slot    (rsp_length_slot),
      .rsp_rate_value     (rsp_rate_value),
      .rsp_frame_total    (rsp_frame_total)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rate_value))
      else $error("result changed while stalled");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_FRAME |->
         rsp_frame_bytes == '0 && rsp_bitpool_slot == '0 && rsp_length_slot == '0)
      else $error("summary item carries frame fields");

   a_frame_sb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_FRAME |->
         (rsp_subband_count == 4'd4 || rsp_subband_count == 4'd8) &&
         rsp_frame_total != '0)
      else $error("bad frame item");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !req_stall |=> !rsp_valid || req_stall ||
         $past(req_valid))
      else $error("result appeared without work");
endmodule

// ----- sim/tb_sbc_stream_frame_analyzer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sbc_stream_frame_analyzer
// Self-checking bench for the SBC stream frame analyzer. Drives a short
// directed sequence of frames and end markers from a table, then random
// well-formed frames with random content, summaries inside headers and
// payloads, and finally a bad sync byte. Every frame and summary is checked
// field by field against a behavioral predictor of the parser, its tables
// and its counters, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_sbc_stream_frame_analyzer;
   import sfa_pkg::*;

   localparam int SLOTS      = 32;
   localparam int FRAC_BITS  = 10;
   localparam int ITEM_COUNT = 1200;
   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_LEN   = 1000;
   localparam int DRAIN_WAIT = 200;

   typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_HALTED} phase_type;
   typedef enum logic [1:0] {ROW_BYTE, ROW_EOS, ROW_PAYLOAD} row_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  pool;
      logic [LEN_W-1:0]   flen;
      logic [SB_W-1:0]    sb;
      logic [BLK_W-1:0]   blk;
      logic [1:0]         freq;
      logic [1:0]         mode;
      logic               alloc;
      logic [SLOT_W-1:0]  pool_slot;
      logic [SLOT_W-1:0]  len_slot;
      logic [RATE_W-1:0]  rate;
      logic [COUNT_W-1:0] total;
   } analysis_type;

   typedef struct {
      row_type            op;
      logic [BYTE_W-1:0]  data;
      bit                 typed;
      logic [KIND_W-1:0]  kind;
      logic [RATE_W-1:0]  rate;
      logic [COUNT_W-1:0] total;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall, req_end_of_stream;
   logic [BYTE_W-1:0] req_stream_byte;
   logic rsp_valid, rsp_stall;
   logic [KIND_W-1:0]  rsp_result_kind;
   logic [BYTE_W-1:0]  rsp_bitpool_value;
   logic [LEN_W-1:0]   rsp_frame_bytes;
   logic [SB_W-1:0]    rsp_subband_count;
   logic [BLK_W-1:0]   rsp_block_count;
   logic [1:0]         rsp_freq_code, rsp_audio_mode;
   logic               rsp_snr_allocation;
   logic [SLOT_W-1:0]  rsp_bitpool_slot, rsp_length_slot;
   logic [RATE_W-1:0]  rsp_rate_value;
   logic [COUNT_W-1:0] rsp_frame_total;

   sbc_stream_frame_analyzer DUT (.*);

   // parser state
   phase_type        m_phase;
   int unsigned      m_hpos;
   logic [7:0]       m_hdr [3];
   int unsigned      m_left;
   logic [7:0]       m_pool_tab [SLOTS];
   logic [10:0]      m_len_tab [SLOTS];
   int unsigned      m_pool_fill, m_len_fill;
   longint unsigned  m_frames, m_rate_sum;

   analysis_type expected_q[$];
   int          fails = 0;
   int          items_sent;
   int          send_idle_pct, recv_idle_pct;
   bit          hold_go;
   bit          hold_done;
   int          hold_left;
   int          quiet_cycles;

   stim_row_type directed [24] = '{
      '{ROW_EOS,     8'h00, 1, KIND_SUM_OK, '0, '0},
      '{ROW_BYTE,    SYNC_BYTE, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'hFF, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'hFF, 0, KIND_FRAME, '0, '0},
      '{ROW_EOS,     8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_EOS,     8'hFF, 0, KIND_FRAME, '0, '0},
      '{ROW_PAYLOAD, 8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    SYNC_BYTE, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'hFF, 0, KIND_FRAME, '0, '0},
      '{ROW_PAYLOAD, 8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    SYNC_BYTE, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h54, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h80, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h55, 0, KIND_FRAME, '0, '0},
      '{ROW_PAYLOAD, 8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    SYNC_BYTE, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'hA8, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'h01, 0, KIND_FRAME, '0, '0},
      '{ROW_BYTE,    8'hAA, 0, KIND_FRAME, '0, '0},
      '{ROW_PAYLOAD, 8'h00, 0, KIND_FRAME, '0, '0},
      '{ROW_EOS,     8'h00, 0, KIND_FRAME, '0, '0}
   };

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int unsigned find_slot8(logic [7:0] v);
      for (int i = 0; i < m_pool_fill; i++)
         if (m_pool_tab[i] == v) return i;
      if (m_pool_fill < SLOTS) begin
         m_pool_tab[m_pool_fill] = v;
         m_pool_fill++;
         return m_pool_fill - 1;
      end
      return SLOTS;
   endfunction

   function automatic int unsigned find_slot11(logic [10:0] v);
      for (int i = 0; i < m_len_fill; i++)
         if (m_len_tab[i] == v) return i;
      if (m_len_fill < SLOTS) begin
         m_len_tab[m_len_fill] = v;
         m_len_fill++;
         return m_len_fill - 1;
      end
      return SLOTS;
   endfunction

   // advance the parser by one accepted item, queue any result it causes
   function automatic void parse_item(logic [7:0] b, logic eos);
      analysis_type    r;
      int unsigned     sb, blk, sbterm, t, body, fb, f10;
      longint unsigned num, den, rate, mean;
      r = '{default: '0};
      if (eos) begin
         if (m_phase == PH_HALTED) r.kind = KIND_SUM_BAD_SYNC;
         else if (m_phase == PH_PAYLOAD) r.kind = KIND_SUM_PART_BODY;
         else if (m_hpos != 0) r.kind = KIND_SUM_PART_HEADER;
         else r.kind = KIND_SUM_OK;
         mean = 0;
         if (m_frames != 0) mean = (m_rate_sum + m_frames / 2) / m_frames;
         if (mean > RATE_MAX) mean = RATE_MAX;
         r.rate  = mean[RATE_W-1:0];
         r.total = m_frames[COUNT_W-1:0];
         expected_q.push_back(r);
         return;
      end
      if (m_phase == PH_HALTED) return;
      if (m_phase == PH_PAYLOAD) begin
         if (m_left > 0) m_left--;
         if (m_left == 0) m_phase = PH_HEADER;
         return;
      end
      if (m_hpos == 0) begin
         if (b != SYNC_BYTE) begin
            m_phase = PH_HALTED;
            return;
         end
         m_hdr[0] = b;
         m_hpos = 1;
         return;
      end
      if (m_hpos < 3) begin
         m_hdr[m_hpos] = b;
         m_hpos++;
         return;
      end
      sb  = (m_hdr[1][0] + 1) * 4;
      blk = (m_hdr[1][5:4] + 1) * 4;
      sbterm = sb;
      case (m_hdr[1][3:2])
         2'd0: begin
            sbterm = sb / 2;
            t = blk * m_hdr[2];
         end
         2'd1: t = blk * m_hdr[2] * 2;
         2'd2: t = blk * m_hdr[2];
         default: t = blk * m_hdr[2] + sb;
      endcase
      body = sbterm + (t + 7) / 8;
      fb   = body + 4;
      case (m_hdr[1][7:6])
         2'd0: f10 = 160;
         2'd1: f10 = 320;
         2'd2: f10 = 441;
         default: f10 = 480;
      endcase
      num  = (longint'(8) * fb * f10) << FRAC_BITS;
      den  = longint'(10) * sb * blk;
      rate = (num + den / 2) / den;
      if (rate > RATE_MAX) rate = RATE_MAX;
      r.kind      = KIND_FRAME;
      r.pool      = m_hdr[2];
      r.flen      = fb[LEN_W-1:0];
      r.sb        = sb[SB_W-1:0];
      r.blk       = blk[BLK_W-1:0];
      r.freq      = m_hdr[1][7:6];
      r.mode      = m_hdr[1][3:2];
      r.alloc     = m_hdr[1][1];
      r.pool_slot = SLOT_W'(find_slot8(m_hdr[2]));
      r.len_slot  = SLOT_W'(find_slot11(fb[10:0]));
      if (m_frames < COUNT_MAX) begin
         m_frames++;
         m_rate_sum += rate;
         if (m_rate_sum > SUM_MAX) m_rate_sum = SUM_MAX;
      end
      r.rate  = rate[RATE_W-1:0];
      r.total = m_frames[COUNT_W-1:0];
      m_hpos  = 0;
      m_left  = body & 11'h7FF;
      m_phase = (m_left != 0) ? PH_PAYLOAD : PH_HEADER;
      expected_q.push_back(r);
   endfunction

   // offer one item, hold it until accepted
   task automatic send_item(logic [7:0] b, logic eos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_stream_byte   = b;
      req_end_of_stream = eos;
      do @(posedge clock); while (req_stall);
      parse_item(b, eos);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_payload();
      while (m_phase == PH_PAYLOAD) begin
         if ($urandom_range(0, 99) < 2) send_item(8'($urandom), 1'b1);
         send_item(8'($urandom), 1'b0);
      end
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic send_frame();
      logic [7:0] pool;
      pool = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      send_item(SYNC_BYTE, 1'b0);
      send_item(8'($urandom), 1'b0);
      if ($urandom_range(0, 99) < 3) send_item(8'($urandom), 1'b1);
      send_item(pool, 1'b0);
      send_item(8'($urandom), 1'b0);
      send_payload();
   endtask

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fails++;
      end
   endtask

   // result side: stall pattern and checking
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      analysis_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result with no expectation, kind %0d", rsp_result_kind);
            fails++;
         end else begin
            e = expected_q.pop_front();
            check_field("result_kind", e.kind, rsp_result_kind);
            check_field("bitpool_value", e.pool, rsp_bitpool_value);
            check_field("frame_bytes", e.flen, rsp_frame_bytes);
            check_field("subband_count", e.sb, rsp_subband_count);
            check_field("block_count", e.blk, rsp_block_count);
            check_field("freq_code", e.freq, rsp_freq_code);
            check_field("audio_mode", e.mode, rsp_audio_mode);
            check_field("snr_allocation", e.alloc, rsp_snr_allocation);
            check_field("bitpool_slot", e.pool_slot, rsp_bitpool_slot);
            check_field("length_slot", e.len_slot, rsp_length_slot);
            check_field("rate_value", e.rate, rsp_rate_value);
            check_field("frame_total", e.total, rsp_frame_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_sbc_stream_frame_analyzer NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      analysis_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_stream_byte = '0;
      req_end_of_stream = 1'b0;
      hold_go = 1'b0;
      items_sent = 0;
      send_idle_pct = 6;
      recv_idle_pct = 60;
      m_phase = PH_HEADER;
      m_hpos = 0;
      m_left = 0;
      m_pool_fill = 0;
      m_len_fill = 0;
      m_frames = 0;
      m_rate_sum = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         case (directed[i].op)
            ROW_PAYLOAD: send_payload();
            ROW_EOS: begin
               if (directed[i].typed) begin
                  // known value after reset
                  while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
                  req_valid = 1'b1;
                  req_stream_byte = directed[i].data;
                  req_end_of_stream = 1'b1;
                  do @(posedge clock); while (req_stall);
                  r = '{default: '0};
                  r.kind  = directed[i].kind;
                  r.rate  = directed[i].rate;
                  r.total = directed[i].total;
                  expected_q.push_back(r);
                  items_sent++;
                  @(negedge clock);
                  req_valid = 1'b0;
               end else begin
                  send_item(directed[i].data, 1'b1);
               end
            end
            default: send_item(directed[i].data, 1'b0);
         endcase
      end

      while (items_sent < ITEM_COUNT) begin
         if (items_sent > ITEM_COUNT / 3 && send_idle_pct == 6) begin
            drain();
            send_idle_pct = 60;
            recv_idle_pct = 6;
            hold_go = 1'b1;
         end else if (items_sent > 2 * ITEM_COUNT / 3 && send_idle_pct == 60) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(0, 99) < 90) send_frame();
         else send_item(8'($urandom), 1'b1);
      end

      // bad sync halts the parser for the rest of the run
      drain();
      send_item(8'h12, 1'b0);
      send_item(SYNC_BYTE, 1'b0);
      send_item(8'($urandom), 1'b0);
      send_item(8'($urandom), 1'b1);
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fails == 0 && expected_q.size() == 0)
         $display("tb_sbc_stream_frame_analyzer OK");
      else
         $display("tb_sbc_stream_frame_analyzer NOT OK");
      $finish;
   end

endmodule
